// ----- hw/rtl/cpf_pkg.sv -----
// package for the crc32 packet framer: request codes, command word, store write
// port and the byte-wise crc-32 update; no dependencies
`default_nettype none

package cpf_pkg;

    // largest payload held in the store
    localparam int MAX_PAYLOAD = 32;
    localparam int STORE_AW    = $clog2(MAX_PAYLOAD);

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // reflected crc-32
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // request codes on the input word
    localparam logic [1:0] REQ_BEGIN   = 2'd0;
    localparam logic [1:0] REQ_NAME    = 2'd1;
    localparam logic [1:0] REQ_PAYLOAD = 2'd2;

    typedef logic [7:0] t_byte;

    typedef enum logic [1:0] {
        CMD_HEADER,
        CMD_NAME,
        CMD_TRAILER,
        CMD_ERROR
    } t_cmd_kind;

    // one unit of work for the back end
    typedef struct packed {
        t_cmd_kind   kind;
        t_byte       data;      // packet type or name byte
        logic [15:0] nlen;      // name length for the header
        logic [5:0]  count;     // payload byte count for the trailer
        logic [31:0] crc;       // final crc for the trailer
        logic        flag;      // packet ends with this word / header
    } t_cmd;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        t_byte               data;
    } t_store_wr;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // one byte through the reflected crc, lsb first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input t_byte b);
        logic [31:0] c;
        c = crc ^ {24'b0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cpf_ifs.sv -----
// valid/ready stream interfaces for the framer input and output words
// depends on nothing
`default_nettype none

interface cpf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  data_byte;
    logic [7:0]  packet_type;
    logic [15:0] name_length;
    logic [5:0]  payload_length;

    modport source (output valid, req_type, data_byte, packet_type, name_length,
                    payload_length, input ready);
    modport sink (input valid, req_type, data_byte, packet_type, name_length,
                  payload_length, output ready);
endinterface

interface cpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       packet_end;
    logic       seq_error;

    modport source (output valid, out_byte, run_last, packet_end, seq_error, input ready);
    modport sink (input valid, out_byte, run_last, packet_end, seq_error, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cpf_front.sv -----
// front end: accepts input words, tracks the packet phase, runs the crc and
// issues commands to the queue; uses cpf_pkg and cpf_in_if
`default_nettype none

module cpf_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    cpf_in_if.sink                 i_in,
    input  wire cpf_pkg::t_q_status i_q_stat,
    input  wire logic              i_drain_done,
    output logic                   o_push,
    output cpf_pkg::t_cmd          o_cmd,
    output cpf_pkg::t_store_wr     o_store_wr
);
    import cpf_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_NAME,
        PH_PAYLOAD
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_name_rem, n_name_rem;
    logic [5:0]  r_expected, n_expected;
    logic [5:0]  r_count, n_count;
    logic [31:0] r_crc, n_crc;
    logic        r_drain_busy, n_drain_busy;

    logic        accept;
    logic        ok;
    logic [31:0] crc_next;
    logic [5:0]  cnt_inc;
    logic        last_name;

    // hold off while the queue is full or the store is being drained
    assign i_in.ready = !i_q_stat.full && !r_drain_busy;
    assign accept     = i_in.valid && i_in.ready;
    assign crc_next   = crc32_byte(r_crc, i_in.data_byte);
    assign cnt_inc    = r_count + 6'd1;
    assign last_name  = (r_name_rem <= 16'd1);

    // classify the word and work out the next phase
    always_comb begin
        n_phase      = r_phase;
        n_name_rem   = r_name_rem;
        n_expected   = r_expected;
        n_count      = r_count;
        n_crc        = r_crc;
        n_drain_busy = r_drain_busy;
        o_push       = 1'b0;
        o_cmd        = '0;
        o_store_wr   = '0;
        ok           = 1'b0;

        if (i_drain_done) begin
            n_drain_busy = 1'b0;
        end

        unique case (i_in.req_type)
            REQ_BEGIN:   ok = (r_phase == PH_IDLE) &&
                              (i_in.payload_length <= 6'(MAX_PAYLOAD));
            REQ_NAME:    ok = (r_phase == PH_NAME);
            REQ_PAYLOAD: ok = (r_phase == PH_PAYLOAD);
            default:     ok = 1'b0;
        endcase

        if (accept) begin
            if (!ok) begin
                // abort the packet, one error word
                o_push     = 1'b1;
                o_cmd.kind = CMD_ERROR;
                n_phase    = PH_IDLE;
                n_name_rem = '0;
                n_expected = '0;
                n_count    = '0;
                n_crc      = CRC_INIT;
            end else if (i_in.req_type == REQ_BEGIN) begin
                o_push     = 1'b1;
                o_cmd.kind = CMD_HEADER;
                o_cmd.data = i_in.packet_type;
                o_cmd.nlen = i_in.name_length;
                o_cmd.flag = (i_in.name_length == 16'd0) && (i_in.payload_length == 6'd0);
                n_name_rem = i_in.name_length;
                n_expected = i_in.payload_length;
                n_count    = '0;
                n_crc      = CRC_INIT;
                if (i_in.name_length != 16'd0) begin
                    n_phase = PH_NAME;
                end else if (i_in.payload_length != 6'd0) begin
                    n_phase = PH_PAYLOAD;
                end else begin
                    n_phase = PH_IDLE;
                end
            end else if (i_in.req_type == REQ_NAME) begin
                o_push     = 1'b1;
                o_cmd.kind = CMD_NAME;
                o_cmd.data = i_in.data_byte;
                o_cmd.flag = last_name && (r_expected == 6'd0);
                n_name_rem = last_name ? 16'd0 : r_name_rem - 16'd1;
                if (last_name) begin
                    n_phase = (r_expected == 6'd0) ? PH_IDLE : PH_PAYLOAD;
                end
            end else begin
                // payload word: store it and fold it into the crc
                o_store_wr.en   = 1'b1;
                o_store_wr.addr = r_count[STORE_AW-1:0];
                o_store_wr.data = i_in.data_byte;
                n_crc           = crc_next;
                n_count         = cnt_inc;
                if (cnt_inc >= r_expected) begin
                    o_push       = 1'b1;
                    o_cmd.kind   = CMD_TRAILER;
                    o_cmd.count  = cnt_inc;
                    o_cmd.crc    = ~crc_next;
                    n_drain_busy = 1'b1;
                    n_phase      = PH_IDLE;
                    n_name_rem   = '0;
                    n_expected   = '0;
                    n_count      = '0;
                    n_crc        = CRC_INIT;
                end
            end
        end
    end

    // phase and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_name_rem   <= '0;
            r_expected   <= '0;
            r_count      <= '0;
            r_crc        <= CRC_INIT;
            r_drain_busy <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_name_rem   <= n_name_rem;
            r_expected   <= n_expected;
            r_count      <= n_count;
            r_crc        <= n_crc;
            r_drain_busy <= n_drain_busy;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cpf_cmd_queue.sv -----
// short command queue between the framer front and back ends
// uses cpf_pkg
`default_nettype none

module cpf_cmd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire cpf_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output cpf_pkg::t_cmd      o_head,
    output cpf_pkg::t_q_status o_stat
);
    import cpf_pkg::*;

    t_cmd          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_AW:0]   r_fill;

    logic do_push;
    logic do_pop;

    assign o_stat.full  = (r_fill == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_fill == '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cpf_back.sv -----
// back end: turns commands into output words, holds the magic register and
// the payload store; uses cpf_pkg and cpf_out_if
`default_nettype none

module cpf_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [15:0]        i_cfg_wr_data,
    input  wire cpf_pkg::t_q_status i_q_stat,
    input  wire cpf_pkg::t_cmd      i_q_head,
    output logic                    o_pop,
    input  wire cpf_pkg::t_store_wr i_store_wr,
    output logic                    o_drain_done,
    cpf_out_if.source               o_out
);
    import cpf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_TRL,
        ST_DRAIN
    } t_state;

    localparam logic [2:0] HDR_LAST = 3'd6;
    localparam logic [2:0] TRL_LAST = 3'd7;

    t_byte               r_store [MAX_PAYLOAD];
    t_byte               r_rd_data;
    logic [15:0]         r_magic;

    t_state              r_state, n_state;
    logic [2:0]          r_step, n_step;
    logic [STORE_AW-1:0] r_idx, n_idx;
    t_cmd                r_cmd, n_cmd;
    logic                r_valid, n_valid;
    t_byte               r_byte, n_byte;
    logic                r_last, n_last;
    logic                r_end, n_end;
    logic                r_err, n_err;

    logic                adv;

    assign o_out.valid      = r_valid;
    assign o_out.out_byte   = r_byte;
    assign o_out.run_last   = r_last;
    assign o_out.packet_end = r_end;
    assign o_out.seq_error  = r_err;

    // output slot free or being taken
    assign adv = !r_valid || o_out.ready;

    // magic register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= '0;
        end else if (i_cfg_wr_en) begin
            r_magic <= i_cfg_wr_data;
        end
    end

    // payload store, with a registered read addressed by the next drain index
    always_ff @(posedge i_clk) begin
        if (i_store_wr.en) begin
            r_store[i_store_wr.addr] <= i_store_wr.data;
        end
        r_rd_data <= r_store[n_idx];
    end

    // sequencer: next output word
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_idx        = r_idx;
        n_cmd        = r_cmd;
        n_valid      = r_valid;
        n_byte       = r_byte;
        n_last       = r_last;
        n_end        = r_end;
        n_err        = r_err;
        o_pop        = 1'b0;
        o_drain_done = 1'b0;

        if (adv) begin
            n_valid = 1'b0;
            n_byte  = '0;
            n_last  = 1'b0;
            n_end   = 1'b0;
            n_err   = 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_stat.empty) begin
                        o_pop   = 1'b1;
                        n_cmd   = i_q_head;
                        n_valid = 1'b1;
                        unique case (i_q_head.kind)
                            CMD_ERROR: begin
                                n_err  = 1'b1;
                                n_last = 1'b1;
                            end
                            CMD_NAME: begin
                                n_byte = i_q_head.data;
                                n_end  = i_q_head.flag;
                                n_last = 1'b1;
                            end
                            CMD_HEADER: begin
                                n_byte  = r_magic[7:0];
                                n_step  = 3'd1;
                                n_state = ST_HDR;
                            end
                            CMD_TRAILER: begin
                                n_byte  = 8'(i_q_head.count);
                                n_step  = 3'd1;
                                n_idx   = '0;
                                n_state = ST_TRL;
                            end
                        endcase
                    end
                end
                ST_HDR: begin
                    n_valid = 1'b1;
                    case (r_step)
                        3'd1:    n_byte = r_magic[15:8];
                        3'd2:    n_byte = r_cmd.data;
                        3'd3:    n_byte = r_cmd.nlen[7:0];
                        3'd4:    n_byte = r_cmd.nlen[15:8];
                        default: n_byte = '0;
                    endcase
                    if (r_step == HDR_LAST) begin
                        n_last  = 1'b1;
                        n_end   = r_cmd.flag;
                        n_state = ST_IDLE;
                    end else begin
                        n_step = r_step + 3'd1;
                    end
                end
                ST_TRL: begin
                    // upper length bytes are zero, then the crc low byte first
                    n_valid = 1'b1;
                    n_idx   = '0;
                    case (r_step)
                        3'd4:    n_byte = r_cmd.crc[7:0];
                        3'd5:    n_byte = r_cmd.crc[15:8];
                        3'd6:    n_byte = r_cmd.crc[23:16];
                        3'd7:    n_byte = r_cmd.crc[31:24];
                        default: n_byte = '0;
                    endcase
                    if (r_step == TRL_LAST) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_step = r_step + 3'd1;
                    end
                end
                ST_DRAIN: begin
                    n_valid = 1'b1;
                    n_byte  = r_rd_data;
                    if (({1'b0, r_idx} + 6'd1) == r_cmd.count) begin
                        n_last       = 1'b1;
                        n_end        = 1'b1;
                        n_idx        = '0;
                        n_state      = ST_IDLE;
                        o_drain_done = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                default: n_state = ST_IDLE;
            endcase
        end
    end

    // state and output word registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
        r_cmd  <= n_cmd;
        r_byte <= n_byte;
        r_last <= n_last;
        r_end  <= n_end;
        r_err  <= n_err;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/crc32_packet_framer_core.sv -----
// crc32 packet framer. output runs at one byte per cycle while the output is ready:
// 7 bytes for a header, 1 for a name byte or an error, 8 plus the payload length
// after the last payload word. input takes one word per cycle until the 4-entry
// command queue fills or a stored payload is being drained.
// reset is synchronous, active low, clears control state and magic; store not cleared
`default_nettype none

module crc32_packet_framer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    cpf_in_if.sink           i_in,
    cpf_out_if.source        o_out
);
    import cpf_pkg::*;

    logic      push;
    logic      pop;
    logic      drain_done;
    t_cmd      cmd;
    t_cmd      head;
    t_q_status q_stat;
    t_store_wr store_wr;

    // word intake and classification
    cpf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_q_stat     (q_stat),
        .i_drain_done (drain_done),
        .o_push       (push),
        .o_cmd        (cmd),
        .o_store_wr   (store_wr)
    );

    // decoupling queue
    cpf_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // output sequencing
    cpf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_stat      (q_stat),
        .i_q_head      (head),
        .o_pop         (pop),
        .i_store_wr    (store_wr),
        .o_drain_done  (drain_done),
        .o_out         (o_out)
    );

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench for crc32_packet_framer_core: framing words go in with random
// gaps, a local model of the framer predicts every output byte and the monitor checks it
// depends on cpf_pkg, the cpf_in_if / cpf_out_if interfaces and the framer core

module testbench;
    import cpf_pkg::*;

    // request code with no meaning to the framer, always an error
    localparam logic [1:0] REQ_BAD = 2'd3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 24;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_NAME,
        FR_PAYLOAD
    } t_frame_phase;

    typedef struct packed {
        logic [1:0]  req;
        t_byte       data;
        t_byte       ptype;
        logic [15:0] nlen;
        logic [5:0]  plen;
    } t_frame_word;

    typedef struct packed {
        t_byte value;
        logic  last;
        logic  pend;
        logic  err;
    } t_frame_byte;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    cpf_in_if  word_in ();
    cpf_out_if byte_out ();

    crc32_packet_framer_core i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (word_in),
        .o_out         (byte_out)
    );

    // framer model state
    logic [15:0]  magic_now;
    t_frame_phase ph;
    logic [15:0]  name_left;
    logic [5:0]   pay_expected;
    logic [5:0]   pay_count;
    logic [31:0]  crc_run;
    t_byte        pay_buf [0:63];

    t_frame_byte frame_exp [$];
    t_frame_word pending [$];

    bit in_hold;
    bit calm;
    bit no_idle;
    int src_gap;
    int snk_stall;
    int cycles = 0;
    int errors;
    int words_made;
    int words_in;
    int bytes_out;
    int seq_errs;

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic t_frame_byte frame_byte(input t_byte v, input logic pend,
                                               input logic err);
        t_frame_byte b;
        b.value = v;
        b.last  = 1'b0;
        b.pend  = pend;
        b.err   = err;
        return b;
    endfunction

    // reflected crc-32, one byte lsb first
    function automatic logic [31:0] crc_step(input logic [31:0] c, input t_byte b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        repeat (8) x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        return x;
    endfunction

    function automatic void frame_clear();
        ph           = FR_IDLE;
        name_left    = '0;
        pay_expected = '0;
        pay_count    = '0;
        crc_run      = CRC_INIT;
    endfunction

    // work out the bytes one accepted word causes and queue them
    task automatic frame_predict(input t_frame_word w);
        t_frame_byte r [$];
        logic        ok;
        logic        last_name;
        logic        done;
        logic        empty;
        logic [31:0] crc_out;
        case (w.req)
            REQ_BEGIN:   ok = (ph == FR_IDLE) && (w.plen <= MAX_PAYLOAD);
            REQ_NAME:    ok = (ph == FR_NAME);
            REQ_PAYLOAD: ok = (ph == FR_PAYLOAD);
            default:     ok = 1'b0;
        endcase
        if (!ok) begin
            // abort the packet with a single error byte
            frame_clear();
            r = {r, frame_byte(8'h00, 1'b0, 1'b1)};
        end else if (w.req == REQ_BEGIN) begin
            empty = (w.nlen == 16'd0) && (w.plen == 6'd0);
            r = {r, frame_byte(magic_now[7:0], 1'b0, 1'b0)};
            r = {r, frame_byte(magic_now[15:8], 1'b0, 1'b0)};
            r = {r, frame_byte(w.ptype, 1'b0, 1'b0)};
            r = {r, frame_byte(w.nlen[7:0], 1'b0, 1'b0)};
            r = {r, frame_byte(w.nlen[15:8], 1'b0, 1'b0)};
            r = {r, frame_byte(8'h00, 1'b0, 1'b0)};
            r = {r, frame_byte(8'h00, empty, 1'b0)};
            name_left    = w.nlen;
            pay_expected = w.plen;
            pay_count    = '0;
            crc_run      = CRC_INIT;
            if (w.nlen != 16'd0) ph = FR_NAME;
            else if (w.plen != 6'd0) ph = FR_PAYLOAD;
            else ph = FR_IDLE;
        end else if (w.req == REQ_NAME) begin
            last_name = (name_left <= 16'd1);
            done      = last_name && (pay_expected == 6'd0);
            r = {r, frame_byte(w.data, done, 1'b0)};
            name_left = last_name ? 16'd0 : name_left - 16'd1;
            if (done) ph = FR_IDLE;
            else if (last_name) ph = FR_PAYLOAD;
        end else begin
            // buffer the payload byte, trailer and drain on the last one
            pay_buf[pay_count] = w.data;
            crc_run   = crc_step(crc_run, w.data);
            pay_count = pay_count + 6'd1;
            if (pay_count >= pay_expected) begin
                crc_out = ~crc_run;
                for (int k = 0; k < 4; k++)
                    r = {r, frame_byte(t_byte'(32'(pay_count) >> (8 * k)), 1'b0, 1'b0)};
                for (int k = 0; k < 4; k++)
                    r = {r, frame_byte(t_byte'(crc_out >> (8 * k)), 1'b0, 1'b0)};
                for (int i = 0; i < pay_count; i++)
                    r = {r, frame_byte(pay_buf[i], (i + 1) == pay_count, 1'b0)};
                frame_clear();
            end
        end
        if (r.size() != 0) r[r.size() - 1].last = 1'b1;
        frame_exp = {frame_exp, r};
    endtask

    // drive both handshakes at the falling edge
    always @(negedge clk) begin
        t_frame_word w;
        if (!rst_n) begin
            word_in.valid  <= 1'b0;
            byte_out.ready <= 1'b0;
        end else begin
            // alternate between calm stretches and stretches with idling
            if ($urandom_range(0, 39) == 0) calm = !calm;
            if (!in_hold) begin
                if (src_gap > 0) begin
                    src_gap--;
                    word_in.valid <= 1'b0;
                end else if (pending.size() != 0) begin
                    w = pending.pop_front();
                    word_in.req_type       <= w.req;
                    word_in.data_byte      <= w.data;
                    word_in.packet_type    <= w.ptype;
                    word_in.name_length    <= w.nlen;
                    word_in.payload_length <= w.plen;
                    word_in.valid          <= 1'b1;
                    in_hold = 1'b1;
                end else begin
                    word_in.valid <= 1'b0;
                end
            end
            // output back-pressure
            if (snk_stall == 0 && !calm && !no_idle && $urandom_range(0, 4) == 0)
                snk_stall = $urandom_range(1, 3);
            if (snk_stall > 0) begin
                snk_stall--;
                byte_out.ready <= 1'b0;
            end else begin
                byte_out.ready <= 1'b1;
            end
        end
    end

    // sample both handshakes at the rising edge
    always @(posedge clk) begin
        t_frame_word w;
        t_frame_byte e;
        cycles++;
        if (rst_n) begin
            if (word_in.valid && word_in.ready) begin
                w.req   = word_in.req_type;
                w.data  = word_in.data_byte;
                w.ptype = word_in.packet_type;
                w.nlen  = word_in.name_length;
                w.plen  = word_in.payload_length;
                frame_predict(w);
                words_in++;
                in_hold = 1'b0;
                if (!calm && !no_idle && $urandom_range(0, 3) == 0)
                    src_gap = $urandom_range(1, 3);
            end
            if (byte_out.valid && byte_out.ready) begin
                bytes_out++;
                if (byte_out.seq_error) seq_errs++;
                if (frame_exp.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h", byte_out.out_byte));
                end else begin
                    e = frame_exp.pop_front();
                    if (byte_out.out_byte !== e.value)
                        report_mismatch($sformatf("byte %0d out_byte %02h, want %02h",
                                                  bytes_out, byte_out.out_byte, e.value));
                    if (byte_out.run_last !== e.last)
                        report_mismatch($sformatf("byte %0d run_last %b, want %b",
                                                  bytes_out, byte_out.run_last, e.last));
                    if (byte_out.packet_end !== e.pend)
                        report_mismatch($sformatf("byte %0d packet_end %b, want %b",
                                                  bytes_out, byte_out.packet_end, e.pend));
                    if (byte_out.seq_error !== e.err)
                        report_mismatch($sformatf("byte %0d seq_error %b, want %b",
                                                  bytes_out, byte_out.seq_error, e.err));
                end
            end
        end
    end

    task automatic add_word(input logic [1:0] req, input t_byte data, input t_byte ptype,
                            input logic [15:0] nlen, input logic [5:0] plen);
        t_frame_word w;
        w.req   = req;
        w.data  = data;
        w.ptype = ptype;
        w.nlen  = nlen;
        w.plen  = plen;
        pending = {pending, w};
        words_made++;
    endtask

    task automatic add_noise();
        add_word(2'($urandom_range(0, 3)), t_byte'($urandom), t_byte'($urandom),
                 16'($urandom), 6'($urandom_range(0, 63)));
    endtask

    // one packet with random content, optionally broken off by a stray word
    task automatic add_packet(input bit broken);
        logic [15:0] nlen;
        logic [5:0]  plen;
        int          body;
        int          cut;
        nlen = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(4, 12))
                                           : 16'($urandom_range(0, 3));
        case ($urandom_range(0, 5))
            0:       plen = 6'd0;
            1:       plen = 6'd32;
            default: plen = 6'($urandom_range(1, 8));
        endcase
        body = nlen + plen;
        cut  = broken ? $urandom_range(0, body) : body + 1;
        add_word(REQ_BEGIN, t_byte'($urandom), t_byte'($urandom), nlen, plen);
        for (int i = 0; i <= body; i++) begin
            if (i == cut) begin
                add_noise();
                break;
            end
            if (i < nlen)
                add_word(REQ_NAME, t_byte'($urandom), t_byte'($urandom), 16'($urandom),
                         6'($urandom));
            else if (i < body)
                add_word(REQ_PAYLOAD, t_byte'($urandom), t_byte'($urandom), 16'($urandom),
                         6'($urandom));
        end
    endtask

    task automatic random_packets(input int n_words);
        int stop;
        stop = words_made + n_words;
        while (words_made < stop) add_packet($urandom_range(0, 4) == 0);
    endtask

    // wait for every expected byte, then give the core time to go quiet
    task automatic settle();
        while (pending.size() != 0 || in_hold || frame_exp.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_magic(input logic [15:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        magic_now = v;
    endtask

    // stimulus and end of run
    initial begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        word_in.valid          = 1'b0;
        word_in.req_type       = REQ_BEGIN;
        word_in.data_byte      = '0;
        word_in.packet_type    = '0;
        word_in.name_length    = '0;
        word_in.payload_length = '0;
        byte_out.ready         = 1'b0;
        in_hold    = 1'b0;
        calm       = 1'b0;
        no_idle    = 1'b0;
        src_gap    = 0;
        snk_stall  = 0;
        errors     = 0;
        words_made = 0;
        words_in   = 0;
        bytes_out  = 0;
        seq_errs   = 0;
        magic_now  = '0;
        frame_clear();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every request and each abort case
        set_magic(16'hFFFF);
        // empty packet ends on the header
        add_word(REQ_BEGIN, 8'hFF, 8'hFF, 16'h0000, 6'd0);
        // name only
        add_word(REQ_BEGIN, 8'h00, 8'h00, 16'h0001, 6'd0);
        add_word(REQ_NAME, 8'hFF, 8'hFF, 16'hFFFF, 6'd63);
        // payload only
        add_word(REQ_BEGIN, 8'h00, 8'h81, 16'h0000, 6'd1);
        add_word(REQ_PAYLOAD, 8'h00, 8'h00, 16'h0000, 6'd0);
        // name then payload
        add_word(REQ_BEGIN, 8'h3C, 8'h7E, 16'h0002, 6'd2);
        add_word(REQ_NAME, 8'h5A, 8'h00, 16'h0000, 6'd0);
        add_word(REQ_NAME, 8'hA5, 8'h00, 16'h0000, 6'd0);
        add_word(REQ_PAYLOAD, 8'hFF, 8'h00, 16'h0000, 6'd0);
        add_word(REQ_PAYLOAD, 8'h01, 8'h00, 16'h0000, 6'd0);
        // out of sequence while idle, bad code, oversized lengths
        add_word(REQ_NAME, 8'h33, 8'h00, 16'h0000, 6'd0);
        add_word(REQ_PAYLOAD, 8'h44, 8'h00, 16'h0000, 6'd0);
        add_word(REQ_BAD, 8'h55, 8'h00, 16'h0000, 6'd0);
        add_word(REQ_BEGIN, 8'h00, 8'h12, 16'h0000, 6'd63);
        add_word(REQ_BEGIN, 8'h00, 8'h12, 16'h0001, 6'd33);
        // longest name and full payload, aborted by a second begin
        add_word(REQ_BEGIN, 8'h00, 8'hC3, 16'hFFFF, 6'd32);
        add_word(REQ_BEGIN, 8'h00, 8'h00, 16'h0000, 6'd0);
        // name word during payload phase
        add_word(REQ_BEGIN, 8'h00, 8'h01, 16'h0000, 6'd2);
        add_word(REQ_NAME, 8'h66, 8'h00, 16'h0000, 6'd0);
        // payload word during name phase
        add_word(REQ_BEGIN, 8'h00, 8'h02, 16'h0001, 6'd0);
        add_word(REQ_PAYLOAD, 8'h77, 8'h00, 16'h0000, 6'd0);
        // bad code in the middle of a name
        add_word(REQ_BEGIN, 8'h00, 8'h03, 16'h0003, 6'd0);
        add_word(REQ_BAD, 8'h88, 8'h00, 16'h0000, 6'd0);
        settle();

        // random packets under several magic settings
        set_magic(16'h0000);
        random_packets(30);
        settle();
        set_magic(16'($urandom));
        random_packets(30);
        settle();
        // last stretch runs without any idling
        no_idle = 1'b1;
        set_magic(16'h5AA5);
        random_packets(30);
        settle();

        $display("run covered %0d words in and %0d bytes out, %0d of them error bytes,",
                 words_in, bytes_out, seq_errs);
        $display("over four magic settings including both extremes; %0d mismatches", errors);
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // watchdog
    initial begin
        while (cycles < CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", cycles);
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/cpf_pkg.sv
hw/rtl/cpf_ifs.sv
hw/rtl/cpf_front.sv
hw/rtl/cpf_cmd_queue.sv
hw/rtl/cpf_back.sv
hw/rtl/crc32_packet_framer_core.sv
dv/testbench.sv
